// ===== src/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int unsigned MAX_SAMPLES    = 1024;
  localparam int unsigned SAMP_AW        = $clog2(MAX_SAMPLES);
  localparam int unsigned SAMP_CW        = SAMP_AW + 1;
  localparam int unsigned MAX_PEAK_SLOTS = 32;
  localparam int unsigned PEAK_AW        = $clog2(MAX_PEAK_SLOTS);
  localparam int unsigned PEAK_CW        = PEAK_AW + 1;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned AMP_IN_W = 24;
  localparam int unsigned AMP_W    = 23;
  localparam int unsigned SEP_W    = 16;
  localparam int unsigned MAXPK_W  = 6;
  localparam int unsigned SUM_W    = TIME_W + PEAK_AW;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS = 8'd1;

  localparam logic [SEP_W-1:0]   MIN_SEP_RESET   = 16'd205;
  localparam logic [MAXPK_W-1:0] MAX_PEAKS_RESET = 6'd10;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [PEAK_AW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/pps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic [23:0] amplitude;
  logic        last_sample;
  modport source (output valid, sample_time, amplitude, last_sample, input ready);
  modport sink (input valid, sample_time, amplitude, last_sample, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] peak_time;
  logic [22:0] peak_amplitude;
  logic        last_peak;
  logic        empty_set;
  logic [31:0] min_gap;
  logic [31:0] max_gap;
  logic [31:0] mean_gap;
  logic [22:0] least_peak_amplitude;
  modport source (output valid, peak_time, peak_amplitude, last_peak, empty_set,
                  min_gap, max_gap, mean_gap, least_peak_amplitude, input ready);
  modport sink (input valid, peak_time, peak_amplitude, last_peak, empty_set,
                min_gap, max_gap, mean_gap, least_peak_amplitude, output ready);
endinterface

interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/peak_picker_min_separation_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Peak picker with a minimum time separation between peaks.
// Samples arrive on in_i, one beat per cycle while the block is loading. Samples
// with an amplitude of zero or below are dropped; up to 1024 are stored. The beat
// that carries last_sample starts the selection, and in_i is not ready until every
// result of that set has been delivered on out_o.
// Selection repeats rounds: each round scans all stored samples through the one
// memory read port and, for each candidate that ranks better than the round's
// best, checks it against the accepted peaks one per cycle. At most max_peaks
// rounds run, with a max_peaks of zero taken as one and one above 32 taken as 32.
// The peaks are then put in time order by P scans (P peaks found), the mean gap
// is formed by a serial divider, and each result beat passes through the EMIT,
// OSET and OUTW states.
// cfg_i takes register writes at any time (always ready); they must be made idle.
// Reset clears the state, the sample count and the output valid, and restores
// min_separation to 205 and max_peaks to 10. The stores hold no reset value.
// When out_o is stalled, the result beat holds and the block waits.
module peak_picker_min_separation_top (
  input  wire       clk_i,
  input  wire       rst_ni,
  pps_in_if.sink    in_i,
  pps_out_if.source out_o,
  pps_cfg_if.sink   cfg_i
);
  import pps_pkg::*;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_RD     = 4'd1;
  localparam logic [3:0] ST_CHK    = 4'd2;
  localparam logic [3:0] ST_CONF   = 4'd3;
  localparam logic [3:0] ST_NEXT   = 4'd4;
  localparam logic [3:0] ST_RND    = 4'd5;
  localparam logic [3:0] ST_ORD    = 4'd6;
  localparam logic [3:0] ST_ORDEND = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_DIVW   = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;
  localparam logic [3:0] ST_OSET   = 4'd11;
  localparam logic [3:0] ST_OUTW   = 4'd12;

  logic [3:0]         st_q, st_d;
  logic [SEP_W-1:0]   minsep_q;
  logic [MAXPK_W-1:0] maxpk_q;
  logic [SAMP_CW-1:0] scnt_q, scnt_d, n_q, n_d;
  logic [SAMP_AW-1:0] sidx_q, sidx_d;
  logic [PEAK_CW-1:0] k_q, k_d, pk_cnt_q, pk_cnt_d, limit_q, limit_d;
  logic [PEAK_CW-1:0] j_q, j_d, e_q, e_d;
  logic               have_last_q, have_last_d;
  logic [AMP_W-1:0]   last_amp_q, last_amp_d;
  logic [SAMP_AW-1:0] last_idx_q, last_idx_d;
  logic               best_v_q, best_v_d;
  logic [AMP_W-1:0]   best_amp_q, best_amp_d, cand_amp_q, cand_amp_d;
  logic [SAMP_AW-1:0] best_idx_q, best_idx_d, cand_idx_q, cand_idx_d;
  logic [TIME_W-1:0]  best_time_q, best_time_d, cand_time_q, cand_time_d;
  logic               obest_v_q, obest_v_d;
  logic [PEAK_AW-1:0] obest_k_q, obest_k_d, prev_k_q, prev_k_d;
  logic [TIME_W-1:0]  obest_t_q, obest_t_d, prev_t_q, prev_t_d;
  logic [AMP_W-1:0]   obest_a_q, obest_a_d;
  logic [TIME_W-1:0]  gmin_q, gmin_d, gmax_q, gmax_d, mean_q, mean_d;
  logic [SUM_W-1:0]   gsum_q, gsum_d;
  logic [AMP_W-1:0]   least_q, least_d;

  logic               ov_q, ov_d, olast_q, olast_d, oempty_q, oempty_d;
  logic [TIME_W-1:0]  otime_q, otime_d, omin_q, omin_d, omax_q, omax_d, omean_q, omean_d;
  logic [AMP_W-1:0]   oamp_q, oamp_d, oleast_q, oleast_d;

  logic [TIME_W-1:0]  pk_time_q [MAX_PEAK_SLOTS];
  logic [AMP_W-1:0]   pk_amp_q  [MAX_PEAK_SLOTS];
  logic [PEAK_AW-1:0] ord_q     [MAX_PEAK_SLOTS];
  logic               pk_we, ord_we;

  logic               in_acc, keep;
  logic [SAMP_CW-1:0] scnt_new;
  logic [TIME_W-1:0]  rd_time, kt, diff, gap;
  logic [AMP_W-1:0]   rd_amp, ka;
  logic               rank_ok, better, elig, obetter;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign in_i.ready  = (st_q == ST_LOAD);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign keep        = !in_i.amplitude[AMP_IN_W-1] && (in_i.amplitude != '0)
                       && (scnt_q < SAMP_CW'(MAX_SAMPLES));
  assign scnt_new    = keep ? scnt_q + 1'b1 : scnt_q;

  pps_sample_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && keep),
    .waddr_i (scnt_q[SAMP_AW-1:0]),
    .wtime_i (in_i.sample_time),
    .wamp_i  (in_i.amplitude[AMP_W-1:0]),
    .raddr_i (sidx_q),
    .rtime_o (rd_time),
    .ramp_o  (rd_amp)
  );

  pps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // All peak store reads go through k_q.
  assign kt   = pk_time_q[k_q[PEAK_AW-1:0]];
  assign ka   = pk_amp_q[k_q[PEAK_AW-1:0]];
  assign diff = (cand_time_q >= kt) ? cand_time_q - kt : kt - cand_time_q;
  assign gap  = obest_t_q - prev_t_q;

  // Rank order is falling amplitude, earlier sample first on a tie.
  assign rank_ok = !have_last_q || (rd_amp < last_amp_q)
                   || ((rd_amp == last_amp_q) && (sidx_q > last_idx_q));
  assign better  = !best_v_q || (rd_amp > best_amp_q);
  assign elig    = (j_q == '0) || (kt > prev_t_q)
                   || ((kt == prev_t_q) && (k_q[PEAK_AW-1:0] > prev_k_q));
  assign obetter = !obest_v_q || (kt < obest_t_q);

  always_comb begin
    st_d = st_q; scnt_d = scnt_q; n_d = n_q; sidx_d = sidx_q; k_d = k_q;
    pk_cnt_d = pk_cnt_q; limit_d = limit_q; j_d = j_q; e_d = e_q;
    have_last_d = have_last_q; last_amp_d = last_amp_q; last_idx_d = last_idx_q;
    best_v_d = best_v_q; best_amp_d = best_amp_q; best_idx_d = best_idx_q;
    best_time_d = best_time_q; cand_amp_d = cand_amp_q; cand_idx_d = cand_idx_q;
    cand_time_d = cand_time_q; obest_v_d = obest_v_q; obest_k_d = obest_k_q;
    obest_t_d = obest_t_q; obest_a_d = obest_a_q; prev_k_d = prev_k_q;
    prev_t_d = prev_t_q; gmin_d = gmin_q; gmax_d = gmax_q; gsum_d = gsum_q;
    least_d = least_q; mean_d = mean_q;
    ov_d = ov_q; olast_d = olast_q; oempty_d = oempty_q; otime_d = otime_q;
    oamp_d = oamp_q; omin_d = omin_q; omax_d = omax_q; omean_d = omean_q;
    oleast_d = oleast_q;
    pk_we = 1'b0; ord_we = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = gsum_q;
    dreq.divisor = PEAK_AW'(pk_cnt_q - 1'b1);

    unique case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          scnt_d = scnt_new;
          if (in_i.last_sample) begin
            scnt_d = '0;
            n_d    = scnt_new;
            if (scnt_new == '0) begin
              ov_d = 1'b1; olast_d = 1'b1; oempty_d = 1'b1;
              otime_d = '0; oamp_d = '0; omin_d = '0; omax_d = '0;
              omean_d = '0; oleast_d = '0;
              st_d = ST_OUTW;
            end else begin
              if (maxpk_q == '0) begin
                limit_d = PEAK_CW'(1);
              end else if (maxpk_q > MAXPK_W'(MAX_PEAK_SLOTS)) begin
                limit_d = PEAK_CW'(MAX_PEAK_SLOTS);
              end else begin
                limit_d = PEAK_CW'(maxpk_q);
              end
              pk_cnt_d = '0; have_last_d = 1'b0; sidx_d = '0; best_v_d = 1'b0;
              st_d = ST_RD;
            end
          end
        end
      end
      ST_RD: st_d = ST_CHK;
      ST_CHK: begin
        cand_time_d = rd_time; cand_amp_d = rd_amp; cand_idx_d = sidx_q;
        st_d = ST_NEXT;
        if (rank_ok && better) begin
          if (pk_cnt_q == '0) begin
            best_v_d = 1'b1; best_amp_d = rd_amp; best_idx_d = sidx_q;
            best_time_d = rd_time;
          end else begin
            k_d  = '0;
            st_d = ST_CONF;
          end
        end
      end
      ST_CONF: begin
        if (diff < TIME_W'(minsep_q)) begin
          st_d = ST_NEXT;
        end else if (k_q + 1'b1 == pk_cnt_q) begin
          best_v_d = 1'b1; best_amp_d = cand_amp_q; best_idx_d = cand_idx_q;
          best_time_d = cand_time_q;
          st_d = ST_NEXT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_NEXT: begin
        if (SAMP_CW'(sidx_q) == n_q - 1'b1) begin
          st_d = ST_RND;
        end else begin
          sidx_d = sidx_q + 1'b1;
          st_d   = ST_RD;
        end
      end
      ST_RND: begin
        j_d = '0; k_d = '0; obest_v_d = 1'b0;
        st_d = ST_ORD;
        if (best_v_q) begin
          pk_we = 1'b1;
          pk_cnt_d = pk_cnt_q + 1'b1;
          have_last_d = 1'b1; last_amp_d = best_amp_q; last_idx_d = best_idx_q;
          if (pk_cnt_q + 1'b1 != limit_q) begin
            sidx_d = '0; best_v_d = 1'b0;
            st_d = ST_RD;
          end
        end
      end
      ST_ORD: begin
        if (elig && obetter) begin
          obest_v_d = 1'b1; obest_k_d = k_q[PEAK_AW-1:0]; obest_t_d = kt; obest_a_d = ka;
        end
        if (k_q + 1'b1 == pk_cnt_q) begin
          st_d = ST_ORDEND;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_ORDEND: begin
        ord_we = 1'b1;
        if (j_q == '0) begin
          least_d = obest_a_q;
          gmin_d = '0; gmax_d = '0; gsum_d = '0;
        end else begin
          if (obest_a_q < least_q) least_d = obest_a_q;
          if ((j_q == PEAK_CW'(1)) || (gap < gmin_q)) gmin_d = gap;
          if (gap > gmax_q) gmax_d = gap;
          gsum_d = gsum_q + SUM_W'(gap);
        end
        prev_t_d = obest_t_q; prev_k_d = obest_k_q;
        j_d = j_q + 1'b1; k_d = '0; obest_v_d = 1'b0;
        st_d = (j_q + 1'b1 == pk_cnt_q) ? ST_DIV : ST_ORD;
      end
      ST_DIV: begin
        if (pk_cnt_q > PEAK_CW'(1)) begin
          dreq.start = 1'b1;
          st_d = ST_DIVW;
        end else begin
          mean_d = '0; e_d = '0;
          st_d = ST_EMIT;
        end
      end
      ST_DIVW: begin
        if (drsp.done) begin
          mean_d = drsp.quotient; e_d = '0;
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        k_d  = PEAK_CW'(ord_q[e_q[PEAK_AW-1:0]]);
        st_d = ST_OSET;
      end
      ST_OSET: begin
        ov_d = 1'b1; oempty_d = 1'b0;
        otime_d = kt; oamp_d = ka;
        olast_d = (e_q + 1'b1 == pk_cnt_q);
        omin_d = '0; omax_d = '0; omean_d = '0; oleast_d = '0;
        if (e_q + 1'b1 == pk_cnt_q) begin
          omin_d = gmin_q; omax_d = gmax_q; omean_d = mean_q; oleast_d = least_q;
        end
        st_d = ST_OUTW;
      end
      ST_OUTW: begin
        if (out_o.ready) begin
          ov_d = 1'b0;
          if (olast_q) begin
            st_d = ST_LOAD;
          end else begin
            e_d  = e_q + 1'b1;
            st_d = ST_EMIT;
          end
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_LOAD;
      scnt_q   <= '0;
      ov_q     <= 1'b0;
      minsep_q <= MIN_SEP_RESET;
      maxpk_q  <= MAX_PEAKS_RESET;
    end else begin
      st_q   <= st_d;
      scnt_q <= scnt_d;
      ov_q   <= ov_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_MIN_SEP) begin
          minsep_q <= cfg_i.data;
        end else if (cfg_i.index == CFG_MAX_PEAKS) begin
          maxpk_q <= cfg_i.data[MAXPK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; sidx_q <= sidx_d; k_q <= k_d; pk_cnt_q <= pk_cnt_d; limit_q <= limit_d;
    j_q <= j_d; e_q <= e_d; have_last_q <= have_last_d; last_amp_q <= last_amp_d;
    last_idx_q <= last_idx_d; best_v_q <= best_v_d; best_amp_q <= best_amp_d;
    best_idx_q <= best_idx_d; best_time_q <= best_time_d; cand_amp_q <= cand_amp_d;
    cand_idx_q <= cand_idx_d; cand_time_q <= cand_time_d; obest_v_q <= obest_v_d;
    obest_k_q <= obest_k_d; obest_t_q <= obest_t_d; obest_a_q <= obest_a_d;
    prev_k_q <= prev_k_d; prev_t_q <= prev_t_d; gmin_q <= gmin_d; gmax_q <= gmax_d;
    gsum_q <= gsum_d; least_q <= least_d; mean_q <= mean_d;
    olast_q <= olast_d; oempty_q <= oempty_d; otime_q <= otime_d; oamp_q <= oamp_d;
    omin_q <= omin_d; omax_q <= omax_d; omean_q <= omean_d; oleast_q <= oleast_d;
    if (pk_we) begin
      pk_time_q[pk_cnt_q[PEAK_AW-1:0]] <= best_time_q;
      pk_amp_q[pk_cnt_q[PEAK_AW-1:0]]  <= best_amp_q;
    end
    if (ord_we) begin
      ord_q[j_q[PEAK_AW-1:0]] <= obest_k_q;
    end
  end

  assign out_o.valid                = ov_q;
  assign out_o.peak_time            = otime_q;
  assign out_o.peak_amplitude       = oamp_q;
  assign out_o.last_peak            = olast_q;
  assign out_o.empty_set            = oempty_q;
  assign out_o.min_gap              = omin_q;
  assign out_o.max_gap              = omax_q;
  assign out_o.mean_gap             = omean_q;
  assign out_o.least_peak_amplitude = oleast_q;

endmodule

`default_nettype wire

// ===== src/pps_sample_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_sample_mem (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [pps_pkg::SAMP_AW-1:0]  waddr_i,
  input  wire  [pps_pkg::TIME_W-1:0]   wtime_i,
  input  wire  [pps_pkg::AMP_W-1:0]    wamp_i,
  input  wire  [pps_pkg::SAMP_AW-1:0]  raddr_i,
  output logic [pps_pkg::TIME_W-1:0]   rtime_o,
  output logic [pps_pkg::AMP_W-1:0]    ramp_o
);
  import pps_pkg::*;

  logic [TIME_W+AMP_W-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wtime_i, wamp_i};
    end
  end

  always_ff @(posedge clk_i) begin
    {rtime_o, ramp_o} <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/pps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pps_div (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire pps_pkg::div_req_t    req_i,
  output pps_pkg::div_rsp_t         rsp_o
);
  import pps_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [PEAK_AW:0]   rem_q, rem_d;
  logic [PEAK_AW-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [PEAK_AW+1:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[SUM_W-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {2'b00, dvs_q}) begin
        rem_d = (PEAK_AW+1)'(trial - {2'b00, dvs_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[PEAK_AW:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q[TIME_W-1:0]};

endmodule

`default_nettype wire
